FILE: sv/assert_macros.svh
// Assertion macros for the FLV tag splitter RTL.
// Every use expects clk and arst_n in scope; checks are disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property with reset disable
`define FTA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication
`define FTA_ASSERT_IMPL(lbl, ante, cons, msg) \
	`FTA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: sv/fta_pkg.sv
// Package for the FLV tag splitter: parse phases, result kinds, beat and result structs.
// No dependencies; all RTL files reference it by scoped names.
package fta_pkg;

	localparam int unsigned CNT_W = 24;

	// Tag framing sizes
	localparam logic [CNT_W-1:0] HDR_BYTES  = CNT_W'(11);
	localparam logic [CNT_W-1:0] BACK_BYTES = CNT_W'(4);

	// Header byte positions
	localparam logic [CNT_W-1:0] HDR_LEN_END  = CNT_W'(3);
	localparam logic [CNT_W-1:0] HDR_TIME_END = CNT_W'(6);
	localparam logic [CNT_W-1:0] HDR_TIME_EXT = CNT_W'(7);

	// Tag types that are streamed
	localparam logic [7:0] TYPE_AUDIO = 8'd8;
	localparam logic [7:0] TYPE_VIDEO = 8'd9;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_BACK    = 2'd2,
		PH_DISCARD = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_GOOD     = 2'd1,
		KIND_MISMATCH = 2'd2,
		KIND_TRUNC    = 2'd3
	} kind_t;

	// One input beat
	typedef struct packed {
		logic [31:0] message_stream;
		logic        last_byte;
		logic [7:0]  data_byte;
	} in_beat_t;

	// One parser result
	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic        is_video;
		logic [31:0] tag_time;
		logic [31:0] tag_stream;
		logic [7:0]  payload_byte;
		logic [23:0] tag_length;
	} result_t;

endpackage

FILE: sv/fta_in_stage.sv
// Input register stage of the FLV tag splitter.
// Depends on fta_pkg (in_beat_t).
module fta_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [39:0]      s_tdata,   // data_byte[7:0], message_stream[39:8]
	input  logic             s_tlast,
	input  logic             step,
	output logic             valid_s1,
	output fta_pkg::in_beat_t beat_s1
);

	// Accept when empty or when the held beat moves on this cycle
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// Beat payload, no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			beat_s1.data_byte      <= s_tdata[7:0];
			beat_s1.message_stream <= s_tdata[39:8];
			beat_s1.last_byte      <= s_tlast;
		end
	end

endmodule

FILE: sv/fta_parser.sv
// Tag parser state machine: header fields, payload and back-size checking per byte.
// Depends on fta_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fta_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  fta_pkg::in_beat_t beat,
	output fta_pkg::result_t  res
);

	fta_pkg::phase_t phase_q, phase_d;
	logic [fta_pkg::CNT_W-1:0] count_q, count_d, count_inc;
	logic [7:0]  type_q, type_d;
	logic [23:0] length_q, length_d;
	logic [31:0] time_q, time_d;
	logic [31:0] back_q, back_d;
	logic [31:0] stream_q, stream_d;
	logic        back_done;
	logic        back_good;

	assign count_inc = count_q + fta_pkg::CNT_W'(1);
	assign back_done = count_inc >= fta_pkg::BACK_BYTES;
	assign back_good = back_d == (32'(length_q) + 32'(fta_pkg::HDR_BYTES));

	// Next state and field updates
	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		type_d   = type_q;
		length_d = length_q;
		time_d   = time_q;
		back_d   = back_q;
		stream_d = stream_q;
		unique case (phase_q)
			fta_pkg::PH_HEADER: begin
				priority if (count_q == '0) begin
					type_d   = beat.data_byte;
					length_d = '0;
					time_d   = '0;
					back_d   = '0;
					stream_d = beat.message_stream;
				end else if (count_q <= fta_pkg::HDR_LEN_END) begin
					length_d = {length_q[15:0], beat.data_byte};
				end else if (count_q <= fta_pkg::HDR_TIME_END) begin
					time_d = {8'h00, time_q[15:0], beat.data_byte};
				end else if (count_q == fta_pkg::HDR_TIME_EXT) begin
					time_d = {beat.data_byte, time_q[23:0]};
				end else begin
					time_d = time_q;
				end
				priority if (beat.last_byte) begin
					phase_d = fta_pkg::PH_HEADER;
					count_d = '0;
				end else if (count_inc >= fta_pkg::HDR_BYTES) begin
					count_d = '0;
					phase_d = (length_d == '0) ? fta_pkg::PH_BACK : fta_pkg::PH_PAYLOAD;
				end else begin
					count_d = count_inc;
				end
			end
			fta_pkg::PH_PAYLOAD: begin
				priority if (beat.last_byte) begin
					phase_d = fta_pkg::PH_HEADER;
					count_d = '0;
				end else if (count_inc >= length_q) begin
					phase_d = fta_pkg::PH_BACK;
					count_d = '0;
				end else begin
					count_d = count_inc;
				end
			end
			fta_pkg::PH_BACK: begin
				back_d = {back_q[23:0], beat.data_byte};
				priority if (back_done) begin
					count_d = '0;
					phase_d = (back_good || beat.last_byte) ? fta_pkg::PH_HEADER
						: fta_pkg::PH_DISCARD;
				end else if (beat.last_byte) begin
					phase_d = fta_pkg::PH_HEADER;
					count_d = '0;
				end else begin
					count_d = count_inc;
				end
			end
			fta_pkg::PH_DISCARD: begin
				if (beat.last_byte) begin
					phase_d = fta_pkg::PH_HEADER;
					count_d = '0;
				end
			end
			default: begin
				phase_d = fta_pkg::PH_HEADER;
				count_d = '0;
			end
		endcase
	end

	// Result for this byte, built from the updated fields
	always_comb begin
		res.valid        = 1'b0;
		res.kind         = fta_pkg::KIND_TRUNC;
		res.payload_byte = '0;
		res.is_video     = type_d == fta_pkg::TYPE_VIDEO;
		res.tag_time     = time_d;
		res.tag_stream   = stream_d;
		res.tag_length   = length_d;
		unique case (phase_q)
			fta_pkg::PH_HEADER: begin
				res.valid = beat.last_byte;
			end
			fta_pkg::PH_PAYLOAD: begin
				if (beat.last_byte) begin
					res.valid = 1'b1;
				end else begin
					res.valid = (type_q == fta_pkg::TYPE_AUDIO) || (type_q == fta_pkg::TYPE_VIDEO);
					res.kind         = fta_pkg::KIND_PAYLOAD;
					res.payload_byte = beat.data_byte;
				end
			end
			fta_pkg::PH_BACK: begin
				if (back_done) begin
					res.valid = 1'b1;
					res.kind  = back_good ? fta_pkg::KIND_GOOD : fta_pkg::KIND_MISMATCH;
				end else begin
					res.valid = beat.last_byte;
				end
			end
			fta_pkg::PH_DISCARD: begin
				res.valid = 1'b0;
			end
			default: begin
				res.valid = 1'b0;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= fta_pkg::PH_HEADER;
			count_q  <= '0;
			type_q   <= '0;
			length_q <= '0;
			time_q   <= '0;
			back_q   <= '0;
			stream_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			type_q   <= type_d;
			length_q <= length_d;
			time_q   <= time_d;
			back_q   <= back_d;
			stream_q <= stream_d;
		end
	end

	`FTA_ASSERT_IMPL(a_payload_len, phase_q == fta_pkg::PH_PAYLOAD, length_q != '0,
		"payload phase with zero tag length")
	`FTA_ASSERT_IMPL(a_hdr_count, phase_q == fta_pkg::PH_HEADER, count_q < fta_pkg::HDR_BYTES,
		"header byte count past header size")
	`FTA_ASSERT_IMPL(a_back_count, phase_q == fta_pkg::PH_BACK, count_q < fta_pkg::BACK_BYTES,
		"back-size byte count past four")
	`FTA_ASSERT_IMPL(a_verdict_zero, res.valid && (res.kind != fta_pkg::KIND_PAYLOAD),
		res.payload_byte == 8'h00, "verdict carries a nonzero payload byte")

endmodule

FILE: sv/fta_out_stage.sv
// Result register of the FLV tag splitter, drives the master-side stream.
// Depends on fta_pkg (result_t).
module fta_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  fta_pkg::result_t res,
	output logic             ready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [95:0]      m_tdata,   // tag_time[31:0], tag_stream[63:32],
	                                    // payload_byte[71:64], tag_length[95:72]
	output logic [2:0]       m_tuser    // kind[1:0], is_video[2]
);

	logic             valid_s2;
	fta_pkg::result_t res_s2;

	// Register can take a new result when empty or being drained
	assign ready = !valid_s2 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= res.valid;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.tag_length, res_s2.payload_byte, res_s2.tag_stream, res_s2.tag_time};
	assign m_tuser  = {res_s2.is_video, res_s2.kind};

endmodule

FILE: sv/flv_aggregate_tag_splitter.sv
// FLV tag splitter: one body byte per beat in, payload bytes and tag verdicts out.
// Beats pass the input register, then the result register; one parse pass per byte.
// Throughput: one byte per cycle unless m_tready low stalls the full result register.
// Bytes that give no result leave no output beat.
// Reset (arst_n low, asynchronous): header phase, all counters and tag fields cleared.
module flv_aggregate_tag_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // data_byte[7:0], message_stream[39:8]
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // tag_time[31:0], tag_stream[63:32],
	                               // payload_byte[71:64], tag_length[95:72]
	output logic [2:0]  m_tuser    // kind[1:0], is_video[2]
);

	logic              valid_s1;
	fta_pkg::in_beat_t beat_s1;
	fta_pkg::result_t  res;
	logic              out_ready;
	logic              step;

	// Held byte is parsed when the result register can take it
	assign step = valid_s1 && out_ready;

	fta_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.step     (step),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	fta_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.beat   (beat_s1),
		.res    (res)
	);

	fta_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.res      (res),
		.ready    (out_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
